@@ rtl/core/lsr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lsr_pkg;

    localparam int unsigned SET_IDX_W = 11;
    localparam int unsigned WAY_IDX_W = 4;

    localparam logic OP_QUERY  = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic capture;   // request taken, row read issued
        logic clr_step;  // write reset row at sweep counter
        logic commit;    // write back updated row or load result
    } lsr_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last;  // sweep counter at last set
        logic is_query;  // request in flight is a victim query
        logic out_stall; // result register full and not drained
    } lsr_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/lru_set_replacement_top.sv @@
// result: the set's rank row is read into a register when the request is taken, and a
//   query then loads the victim into the result register, waiting while an earlier
//   result is not taken; s_ready stays low until the row is written back or the victim returned
// reset: synchronous active-low aresetn; afterwards a clearing pass writes
//   the initial ranks into every set, with s_ready held low
`timescale 1ns / 1ps
`default_nettype none

module lru_set_replacement_top #(
    parameter int unsigned NUM_SETS = 2048,
    parameter int unsigned NUM_WAYS = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_op,
    input  wire logic [lsr_pkg::SET_IDX_W-1:0] s_set_index,
    input  wire logic [lsr_pkg::WAY_IDX_W-1:0] s_access_way,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [lsr_pkg::WAY_IDX_W-1:0]      m_victim_way
);
    import lsr_pkg::*;

    lsr_cmd_t cmd;
    lsr_sts_t sts;

    lsr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    lsr_datapath #(
        .NUM_SETS (NUM_SETS),
        .NUM_WAYS (NUM_WAYS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_op         (s_op),
        .s_set_index  (s_set_index),
        .s_access_way (s_access_way),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_victim_way (m_victim_way),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule

`default_nettype wire

@@ rtl/core/lsr_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lsr_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire lsr_pkg::lsr_sts_t sts,
    output lsr_pkg::lsr_cmd_t     cmd
);
    import lsr_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROC
    } state_t;

    state_t state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            unique case (state_reg)
                ST_CLEAR: begin
                    if (sts.clr_last) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_PROC;
                    end
                end
                ST_PROC: begin
                    if (cmd.commit) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_CLEAR;
                end
            endcase
        end
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign cmd.capture  = (state_reg == ST_IDLE) && s_valid;
    assign cmd.clr_step = (state_reg == ST_CLEAR);
    // a query waits while the result register holds a victim that is not yet taken
    assign cmd.commit   = (state_reg == ST_PROC) && (!sts.is_query || !sts.out_stall);

`ifndef SYNTHESIS
    a_commit_returns: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> s_ready)
        else $error("commit did not return to idle");

    a_no_clear_after_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |=> !cmd.clr_step)
        else $error("clearing pass restarted after idle");
`endif

endmodule

`default_nettype wire

@@ rtl/core/lsr_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lsr_datapath #(
    parameter int unsigned NUM_SETS = 2048,
    parameter int unsigned NUM_WAYS = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_op,
    input  wire logic [lsr_pkg::SET_IDX_W-1:0]     s_set_index,
    input  wire logic [lsr_pkg::WAY_IDX_W-1:0]     s_access_way,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [lsr_pkg::WAY_IDX_W-1:0]          m_victim_way,
    input  wire lsr_pkg::lsr_cmd_t                 cmd,
    output lsr_pkg::lsr_sts_t                      sts
);
    import lsr_pkg::*;

    localparam int unsigned SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int unsigned RANK_W = $clog2(NUM_WAYS);
    localparam int unsigned WAY_W  = RANK_W;

    typedef logic [NUM_WAYS-1:0][RANK_W-1:0] row_t;

    row_t mem [NUM_SETS];

    row_t              rd_row_reg;
    logic              op_reg;
    logic              set_ok_reg;
    logic              way_ok_reg;
    logic [WAY_W-1:0]  way_reg;
    logic [SET_W-1:0]  addr_reg;
    logic [SET_W-1:0]  clr_cnt_reg;
    logic [SET_W-1:0]  clr_cnt_next;
    logic              m_valid_reg;
    logic              m_valid_next;
    logic [WAY_IDX_W-1:0] victim_reg;
    logic [WAY_IDX_W-1:0] victim_next;

    logic [31:0]       set_ext;
    logic [31:0]       way_ext;
    logic [SET_W-1:0]  rd_addr;
    logic [WAY_W-1:0]  way_in;
    row_t              reset_row;
    row_t              upd_row;
    row_t              wr_row;
    logic [SET_W-1:0]  wr_addr;
    logic              mem_we;
    logic [RANK_W-1:0] old_rank;
    logic [WAY_W-1:0]  found_way;
    logic [31:0]       found_ext;
    logic              upd_ok;

    assign set_ext = 32'(s_set_index);
    assign way_ext = 32'(s_access_way);
    assign rd_addr = set_ext[SET_W-1:0];
    assign way_in  = way_ext[WAY_W-1:0];

    for (genvar w = 0; w < NUM_WAYS; w++) begin : g_reset_row
        assign reset_row[w] = RANK_W'(w);
    end

    // promote: ranks below the accessed way's rank move up, accessed way to front
    assign old_rank = rd_row_reg[way_reg];
    for (genvar w = 0; w < NUM_WAYS; w++) begin : g_upd
        always_comb begin
            if (way_reg == WAY_W'(w)) begin
                upd_row[w] = '0;
            end else if (rd_row_reg[w] < old_rank) begin
                upd_row[w] = rd_row_reg[w] + RANK_W'(1);
            end else begin
                upd_row[w] = rd_row_reg[w];
            end
        end
    end

    // lowest way holding the top rank
    always_comb begin
        found_way = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (rd_row_reg[w] == RANK_W'(NUM_WAYS - 1)) begin
                found_way = WAY_W'(w);
            end
        end
    end
    assign found_ext = 32'(found_way);

    assign upd_ok  = (op_reg == OP_UPDATE) && set_ok_reg && way_ok_reg;
    assign mem_we  = cmd.clr_step || (cmd.commit && upd_ok);
    assign wr_addr = cmd.clr_step ? clr_cnt_reg : addr_reg;
    assign wr_row  = cmd.clr_step ? reset_row : upd_row;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_row;
        end
        if (cmd.capture) begin
            rd_row_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg     <= s_op;
            set_ok_reg <= (set_ext < NUM_SETS);
            way_ok_reg <= (way_ext < NUM_WAYS);
            way_reg    <= way_in;
            addr_reg   <= rd_addr;
        end
    end

    always_comb begin
        clr_cnt_next = clr_cnt_reg;
        if (cmd.clr_step) begin
            clr_cnt_next = clr_cnt_reg + SET_W'(1);
        end
        m_valid_next = m_valid_reg && !m_ready;
        victim_next  = victim_reg;
        if (cmd.commit && (op_reg == OP_QUERY)) begin
            m_valid_next = 1'b1;
            victim_next  = set_ok_reg ? found_ext[WAY_IDX_W-1:0] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        victim_reg <= victim_next;
    end

    assign sts.clr_last  = (clr_cnt_reg == SET_W'(NUM_SETS - 1));
    assign sts.is_query  = (op_reg == OP_QUERY);
    assign sts.out_stall = m_valid_reg && !m_ready;

    assign m_valid      = m_valid_reg;
    assign m_victim_way = victim_reg;

`ifndef SYNTHESIS
    a_result_from_query: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid_reg || m_ready) && m_valid_next |-> cmd.commit && (op_reg == OP_QUERY))
        else $error("result loaded without a query commit");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |=> m_valid_reg && $stable(victim_reg))
        else $error("pending result overwritten");

    a_bad_set_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit && (op_reg == OP_QUERY) && !set_ok_reg |=> victim_reg == '0)
        else $error("out of range set gave nonzero victim");

    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_we && cmd.capture))
        else $error("row write collides with row read");
`endif

endmodule

`default_nettype wire
